// ===== src/cfmac_pkg.sv =====
package cfmac_pkg;

	localparam int IP_W   = 16;
	localparam int ACC_W  = 44;
	localparam int APB_AW = 5;

	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-64'sh0000_0000_8000_0000);

	typedef enum logic [1:0] {
		MODE_WEIGHT  = 2'd0,
		MODE_BIAS    = 2'd1,
		MODE_SAMPLE  = 2'd2,
		MODE_COMPUTE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SAT   = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_IN_CH   = 3'd0,
		REG_OUT_CH  = 3'd1,
		REG_TAPS    = 3'd2,
		REG_STRIDE  = 3'd3,
		REG_PAD     = 3'd4,
		REG_SPACING = 3'd5,
		REG_LEN     = 3'd6
	} reg_idx_t;

endpackage

// ===== src/cfmac_if.sv =====
interface cfmac_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [2:0]         out_chan;
	logic [2:0]         in_chan;
	logic [2:0]         tap;
	logic [7:0]         position;
	logic signed [15:0] small_value;
	logic signed [31:0] bias_value;

	modport source (
		output valid, mode, out_chan, in_chan, tap, position, small_value, bias_value,
		input  ready
	);
	modport sink (
		input  valid, mode, out_chan, in_chan, tap, position, small_value, bias_value,
		output ready
	);
endinterface

interface cfmac_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic [1:0]         status;

	modport source (output valid, result, status, input ready);
	modport sink (input valid, result, status, output ready);
endinterface

// ===== src/cfmac_ram.sv =====
module cfmac_ram #(
	parameter int W = 16,
	parameter int D = 512
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                        wdata,
	input  logic                                re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                        rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/conv1d_forward_mac_core.sv =====
// Channel  Dir  Handshake       Payload
// req      in   valid/ready     mode, out_chan, in_chan, tap, position, small_value, bias_value
// rsp      out  valid/ready     result, status
// apb      in   psel/penable    paddr, pwdata, pwrite -> prdata (pready tied high)
//
// Store writes are taken in S_IDLE. A compute item passes S_SETUP and S_CHECK; a rejected
// item then goes to S_FIN, else each tap costs one memory read overlapped with the
// accumulate, then a 16x4 radix-16 serial multiply in S_MUL, before S_FIN.
// One compute item is worked on at a time; new items, stores too, are taken while a result waits.
// arst_n resets control and configuration; stores hold undefined data until written.
module conv1d_forward_mac_core import cfmac_pkg::*; #(
	parameter int MAX_IN_CH  = 8,
	parameter int MAX_OUT_CH = 8,
	parameter int MAX_TAPS   = 8,
	parameter int MAX_LEN    = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	cfmac_req_if.sink         req,
	cfmac_rsp_if.source       rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int ICW  = MAX_IN_CH > 1 ? $clog2(MAX_IN_CH) : 1;
	localparam int OCW  = MAX_OUT_CH > 1 ? $clog2(MAX_OUT_CH) : 1;
	localparam int TPW  = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
	localparam int LW   = $clog2(MAX_LEN);
	localparam int LENW = $clog2(MAX_LEN + 1);
	localparam int WD   = 2 ** (OCW + ICW + TPW);
	localparam int SD   = 2 ** (ICW + LW);
	localparam int BD   = 2 ** OCW;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SETUP = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_RD    = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_ACC   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [3:0] in_channels_q, out_channels_q, kernel_taps_q, zero_pad_q;
	logic [4:0] step_stride_q, tap_spacing_q;
	logic [8:0] input_length_q;

	// config port
	logic     apb_wr;
	reg_idx_t apb_idx;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite && pready;
	assign apb_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q  <= 4'd1;
			out_channels_q <= 4'd1;
			kernel_taps_q  <= 4'd3;
			step_stride_q  <= 5'd1;
			zero_pad_q     <= 4'd0;
			tap_spacing_q  <= 5'd1;
			input_length_q <= 9'd256;
		end else if (apb_wr) begin
			case (apb_idx)
				REG_IN_CH:   in_channels_q  <= pwdata[3:0];
				REG_OUT_CH:  out_channels_q <= pwdata[3:0];
				REG_TAPS:    kernel_taps_q  <= pwdata[3:0];
				REG_STRIDE:  step_stride_q  <= pwdata[4:0];
				REG_PAD:     zero_pad_q     <= pwdata[3:0];
				REG_SPACING: tap_spacing_q  <= pwdata[4:0];
				REG_LEN:     input_length_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (apb_idx)
			REG_IN_CH:   prdata = 32'(in_channels_q);
			REG_OUT_CH:  prdata = 32'(out_channels_q);
			REG_TAPS:    prdata = 32'(kernel_taps_q);
			REG_STRIDE:  prdata = 32'(step_stride_q);
			REG_PAD:     prdata = 32'(zero_pad_q);
			REG_SPACING: prdata = 32'(tap_spacing_q);
			REG_LEN:     prdata = 32'(input_length_q);
			default:     prdata = 32'd0;
		endcase
	end

	// effective counts
	logic [ICW-1:0]  n_in_m1;
	logic [OCW-1:0]  n_out_m1;
	logic [TPW-1:0]  taps_m1;
	logic [4:0]      stride_e, spacing_e;
	logic [LENW-1:0] len_e;

	always_comb begin
		if (in_channels_q == 4'd0) begin
			n_in_m1 = '0;
		end else if (32'(in_channels_q) > MAX_IN_CH) begin
			n_in_m1 = ICW'(MAX_IN_CH - 1);
		end else begin
			n_in_m1 = ICW'(in_channels_q - 4'd1);
		end
		if (out_channels_q == 4'd0) begin
			n_out_m1 = '0;
		end else if (32'(out_channels_q) > MAX_OUT_CH) begin
			n_out_m1 = OCW'(MAX_OUT_CH - 1);
		end else begin
			n_out_m1 = OCW'(out_channels_q - 4'd1);
		end
		if (kernel_taps_q == 4'd0) begin
			taps_m1 = '0;
		end else if (32'(kernel_taps_q) > MAX_TAPS) begin
			taps_m1 = TPW'(MAX_TAPS - 1);
		end else begin
			taps_m1 = TPW'(kernel_taps_q - 4'd1);
		end
		if (input_length_q == 9'd0) begin
			len_e = LENW'(1);
		end else if (32'(input_length_q) > MAX_LEN) begin
			len_e = LENW'(MAX_LEN);
		end else begin
			len_e = LENW'(input_length_q);
		end
		stride_e  = (step_stride_q == 5'd0) ? 5'd1 : step_stride_q;
		spacing_e = (tap_spacing_q == 5'd0) ? 5'd1 : tap_spacing_q;
	end

	// store writes
	logic req_acc;
	logic w_we, b_we, s_we;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign w_we = req_acc && (mode_t'(req.mode) == MODE_WEIGHT)
		&& (32'(req.out_chan) < MAX_OUT_CH) && (32'(req.in_chan) < MAX_IN_CH)
		&& (32'(req.tap) < MAX_TAPS);
	assign b_we = req_acc && (mode_t'(req.mode) == MODE_BIAS)
		&& (32'(req.out_chan) < MAX_OUT_CH);
	assign s_we = req_acc && (mode_t'(req.mode) == MODE_SAMPLE)
		&& (32'(req.in_chan) < MAX_IN_CH) && (32'(req.position) < MAX_LEN);

	// datapath registers
	logic [2:0]              oc_q;
	logic [7:0]              pos_q;
	logic signed [IP_W-1:0]  base_q, ip_q;
	logic [9:0]              span_q;
	logic [ICW-1:0]          c_q;
	logic [TPW-1:0]          k_q;
	logic                    inr_q, last_q, err_q;
	logic [1:0]              dig_q;
	logic signed [31:0]      p_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    ov_q;
	logic signed [31:0]      result_q;
	status_t                 status_q;

	logic issue;
	logic [15:0] w_rd, x_rd;
	logic [31:0] b_rd;

	assign issue = (state_q == S_RD) || (state_q == S_ACC && !last_q);

	cfmac_ram #(.W(16), .D(WD)) u_wram (
		.clk  (clk),
		.we   (w_we),
		.waddr({OCW'(req.out_chan), ICW'(req.in_chan), TPW'(req.tap)}),
		.wdata(req.small_value),
		.re   (issue),
		.raddr({OCW'(oc_q), c_q, k_q}),
		.rdata(w_rd)
	);

	cfmac_ram #(.W(32), .D(BD)) u_bram (
		.clk  (clk),
		.we   (b_we),
		.waddr(OCW'(req.out_chan)),
		.wdata(req.bias_value),
		.re   (state_q == S_SETUP),
		.raddr(OCW'(oc_q)),
		.rdata(b_rd)
	);

	cfmac_ram #(.W(16), .D(SD)) u_sram (
		.clk  (clk),
		.we   (s_we),
		.waddr({ICW'(req.in_chan), LW'(req.position)}),
		.wdata(req.small_value),
		.re   (issue),
		.raddr({c_q, ip_q[LW-1:0]}),
		.rdata(x_rd)
	);

	// address and range arithmetic
	logic [12:0]            pstr;
	logic [9:0]             span_nx;
	logic signed [IP_W-1:0] last_ip, len_s;
	logic                   req_ok, ip_in;

	assign pstr    = 13'(pos_q) * 13'(stride_e);
	assign span_nx = 10'(spacing_e) * 10'(taps_m1);
	assign len_s   = $signed(IP_W'(len_e));
	assign last_ip = base_q + $signed(IP_W'(span_q)) - $signed(IP_W'(zero_pad_q));
	assign req_ok  = (32'(oc_q) <= 32'(n_out_m1)) && (last_ip < len_s);
	assign ip_in   = !ip_q[IP_W-1] && (ip_q < len_s);

	// radix-16 serial multiply, most significant digit first
	logic [3:0]         dig;
	logic               dsgn;
	logic signed [20:0] prod;
	logic signed [31:0] p_nx;

	always_comb begin
		case (dig_q)
			2'd0:    dig = x_rd[15:12];
			2'd1:    dig = x_rd[11:8];
			2'd2:    dig = x_rd[7:4];
			2'd3:    dig = x_rd[3:0];
			default: dig = 4'd0;
		endcase
	end

	// taps outside the input contribute nothing, whatever the stores return
	assign dsgn  = (dig_q == 2'd0) ? dig[3] : 1'b0;
	assign prod  = inr_q ? $signed(w_rd) * $signed({dsgn, dig}) : 21'sd0;
	assign p_nx  = ((dig_q == 2'd0) ? 32'sd0 : (p_q <<< 4)) + 32'(prod);

	// control
	logic fin_load;

	assign fin_load = (state_q == S_FIN) && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (fin_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc && mode_t'(req.mode) == MODE_COMPUTE) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: state_q <= S_CHECK;
				S_CHECK: state_q <= req_ok ? S_RD : S_FIN;
				S_RD:    state_q <= S_MUL;
				S_MUL: begin
					if (dig_q == 2'd3) begin
						state_q <= S_ACC;
					end
				end
				S_ACC:   state_q <= last_q ? S_FIN : S_MUL;
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			oc_q  <= req.out_chan;
			pos_q <= req.position;
		end
		if (state_q == S_SETUP) begin
			base_q <= $signed(IP_W'(pstr)) - $signed(IP_W'(zero_pad_q));
			span_q <= span_nx;
		end
		if (state_q == S_CHECK) begin
			acc_q <= ACC_W'($signed(b_rd));
			ip_q  <= base_q;
			c_q   <= '0;
			k_q   <= '0;
			err_q <= !req_ok;
		end
		if (issue) begin
			inr_q  <= ip_in;
			last_q <= (c_q == n_in_m1) && (k_q == taps_m1);
			dig_q  <= 2'd0;
			if (k_q == taps_m1) begin
				k_q  <= '0;
				c_q  <= c_q + ICW'(1);
				ip_q <= base_q;
			end else begin
				k_q  <= k_q + TPW'(1);
				ip_q <= ip_q + $signed(IP_W'(spacing_e));
			end
		end
		if (state_q == S_MUL) begin
			p_q   <= p_nx;
			dig_q <= dig_q + 2'd1;
		end
		if (state_q == S_ACC) begin
			acc_q <= acc_q + ACC_W'(p_q);
		end
		if (fin_load) begin
			if (err_q) begin
				result_q <= 32'sd0;
				status_q <= STAT_RANGE;
			end else if (acc_q > ACC_HI) begin
				result_q <= 32'sh7FFF_FFFF;
				status_q <= STAT_SAT;
			end else if (acc_q < ACC_LO) begin
				result_q <= -32'sh7FFF_FFFF - 32'sd1;
				status_q <= STAT_SAT;
			end else begin
				result_q <= 32'(acc_q);
				status_q <= STAT_OK;
			end
		end
	end

	assign rsp.valid  = ov_q;
	assign rsp.result = result_q;
	assign rsp.status = status_q;

endmodule

// ===== src/cfmac_checker.sv =====
module cfmac_checker import cfmac_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [1:0]        req_mode,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic signed [31:0] rsp_result,
	input logic [1:0]        rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status))
		else $error("result item changed while stalled");

	a_busy_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_mode == MODE_COMPUTE |=> !req_ready)
		else $error("item taken while a compute is in progress");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_RANGE |-> rsp_result == 32'sd0)
		else $error("rejected request with non-zero result");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_SAT |->
			rsp_result == 32'sh7FFF_FFFF || rsp_result == (-32'sh7FFF_FFFF - 32'sd1))
		else $error("saturated result not at a bound");

endmodule

bind conv1d_forward_mac_core cfmac_checker u_cfmac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_mode  (req.mode),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_result(rsp.result),
	.rsp_status(rsp.status)
);
